### rtl/core/ctlm_pkg.sv
// ----------------------------------------------------------------------------
// ctlm_pkg: shared types and constants for the RC charge-time light meter
// Phase, status and pin codes, register indexes, reset values and the
// packed state and result records that pass between the modules.
// ----------------------------------------------------------------------------
package ctlm_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [TimeW-1:0] DischargeReset = 32'd1000;
	localparam logic [TimeW-1:0] TimeoutReset   = 32'd1000000;

	// register indexes on the configuration channel
	localparam logic [CfgIdxW-1:0] RegDischarge = 2'd0;
	localparam logic [CfgIdxW-1:0] RegTimeout   = 2'd1;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_LEVEL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_DISCHARGE = 2'd1,
		PH_CHARGE    = 2'd2,
		PH_COMPLETE  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_VALID     = 2'd1,
		ST_SATURATED = 2'd2,
		ST_TIMEOUT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PIN_NONE    = 2'd0,
		PIN_LOW     = 2'd1,
		PIN_RELEASE = 2'd2
	} pin_t;

	typedef struct packed {
		phase_t           phase;
		logic [TimeW-1:0] start_us;
		status_t          status;
		logic [TimeW-1:0] charge_time;
	} meter_state_t;

	// packed lowest field last: active is the top bit
	typedef struct packed {
		logic             active;
		logic [TimeW-1:0] charge_time;
		status_t          status;
		logic             done;
		pin_t             pin;
	} result_t;

	localparam int unsigned ResultW = $bits(result_t);
	localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;
	localparam int unsigned InDataW  = ((TimeW + 1 + 7) / 8) * 8;

endpackage

### rtl/core/ctlm_step.sv
// ----------------------------------------------------------------------------
// ctlm_step: next-state and result logic for one input item
// One wrapping subtract, three compares on the elapsed time and the phase update.
// ----------------------------------------------------------------------------
module ctlm_step (
	input  logic [1:0]                 op,
	input  logic [ctlm_pkg::TimeW-1:0] now_us,
	input  logic                       level_high,
	input  logic [ctlm_pkg::TimeW-1:0] discharge_time_us,
	input  logic [ctlm_pkg::TimeW-1:0] charge_timeout_us,
	input  ctlm_pkg::meter_state_t     state,
	output ctlm_pkg::meter_state_t     state_nxt,
	output ctlm_pkg::result_t          res
);

	logic [ctlm_pkg::TimeW-1:0] elapsed;
	ctlm_pkg::pin_t             pin;
	logic                       done;

	assign elapsed = now_us - state.start_us;

	always_comb begin
		state_nxt = state;
		pin       = ctlm_pkg::PIN_NONE;
		done      = 1'b0;
		case (op)
			ctlm_pkg::OP_START: begin
				state_nxt.phase       = ctlm_pkg::PH_DISCHARGE;
				state_nxt.start_us    = now_us;
				state_nxt.status      = ctlm_pkg::ST_NONE;
				state_nxt.charge_time = '0;
				pin                   = ctlm_pkg::PIN_LOW;
			end
			ctlm_pkg::OP_TICK: begin
				if (state.phase == ctlm_pkg::PH_DISCHARGE) begin
					if (elapsed >= discharge_time_us) begin
						state_nxt.phase    = ctlm_pkg::PH_CHARGE;
						state_nxt.start_us = now_us;
						pin                = ctlm_pkg::PIN_RELEASE;
					end
				end else if (state.phase == ctlm_pkg::PH_CHARGE) begin
					// timeout wins over a high level on the same tick
					if (elapsed >= charge_timeout_us) begin
						state_nxt.phase       = ctlm_pkg::PH_COMPLETE;
						state_nxt.status      = ctlm_pkg::ST_TIMEOUT;
						state_nxt.charge_time = '0;
						done                  = 1'b1;
					end else if (level_high) begin
						state_nxt.phase = ctlm_pkg::PH_COMPLETE;
						if (elapsed == '0) begin
							state_nxt.status      = ctlm_pkg::ST_SATURATED;
							state_nxt.charge_time = '0;
						end else begin
							state_nxt.status      = ctlm_pkg::ST_VALID;
							state_nxt.charge_time = elapsed;
						end
						done = 1'b1;
					end
				end
			end
			ctlm_pkg::OP_LEVEL: begin
				if (state.phase == ctlm_pkg::PH_CHARGE && level_high) begin
					state_nxt.phase       = ctlm_pkg::PH_COMPLETE;
					state_nxt.status      = ctlm_pkg::ST_SATURATED;
					state_nxt.charge_time = '0;
					done                  = 1'b1;
				end
			end
			default: begin
				// unused op: no change
			end
		endcase
	end

	always_comb begin
		res.pin         = pin;
		res.done        = done;
		res.status      = state_nxt.status;
		res.charge_time = state_nxt.charge_time;
		res.active      = (state_nxt.phase == ctlm_pkg::PH_DISCHARGE) ||
		                  (state_nxt.phase == ctlm_pkg::PH_CHARGE);
	end

endmodule

### rtl/core/ctlm_out_buf.sv
// ----------------------------------------------------------------------------
// ctlm_out_buf: result register with skid stage
// Holds up to two results so that ready towards the source is registered.
// ----------------------------------------------------------------------------
module ctlm_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ctlm_pkg::result_t push_data,
	output logic              space,
	output logic              head_valid,
	input  logic              head_ready,
	output ctlm_pkg::result_t head_data
);

	logic              head_valid_q;
	ctlm_pkg::result_t head_q;
	logic              skid_valid_q;
	ctlm_pkg::result_t skid_q;
	logic              pop;

	assign pop        = head_valid_q && head_ready;
	assign space      = !skid_valid_q;
	assign head_valid = head_valid_q;
	assign head_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					head_valid_q <= 1'b1;
					skid_valid_q <= push;
				end else begin
					head_valid_q <= push;
				end
			end else if (!head_valid_q) begin
				head_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (!head_valid_q) begin
			head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

### rtl/core/rc_charge_time_light_meter_top.sv
// ----------------------------------------------------------------------------
// rc_charge_time_light_meter_top: RC charge-time light meter
// Times how long an RC sensor pin takes to charge after a discharge period.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transfer when           | carries
//  ---------+-----------+-------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid & tready  | op on tuser, time/level tdata
//  m_axis   | out       | m_axis_tvalid & tready  | one result per input item
//  cfg      | in        | cfg_valid & cfg_ready   | register index and value
//
//  Each input transfer is evaluated in the cycle it is taken: the state
//  registers and the result register (or, if that is full, the skid stage)
//  load at the same edge, so an item can be taken every cycle while
//  s_axis_tready is high. The result register is backed by a skid stage;
//  s_axis_tready only drops once both are full.
//  Reset clears the state, empties the output and loads the register
//  defaults (discharge 1000 us, timeout 1000000 us). cfg_ready is always high.
//
module rc_charge_time_light_meter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] now_us, [32] level_high, [39:33] zero
	input  logic [ctlm_pkg::InDataW-1:0]        s_axis_tdata,
	// [1:0] op
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [1:0] pin_action, [2] done_res, [4:3] result_status, [36:5] charge_time,
	// [37] active, [39:38] zero
	output logic [ctlm_pkg::OutDataW-1:0]       m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ctlm_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [ctlm_pkg::TimeW-1:0]          cfg_data
);

	logic [ctlm_pkg::TimeW-1:0] discharge_q;
	logic [ctlm_pkg::TimeW-1:0] timeout_q;
	ctlm_pkg::meter_state_t     state_q;
	ctlm_pkg::meter_state_t     state_nxt;
	ctlm_pkg::result_t          res;
	ctlm_pkg::result_t          head;
	logic                       in_xfer;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_axis_tvalid && s_axis_tready;

	// configuration registers; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discharge_q <= ctlm_pkg::DischargeReset;
			timeout_q   <= ctlm_pkg::TimeoutReset;
		end else if (cfg_valid) begin
			if (cfg_index == ctlm_pkg::RegDischarge) begin
				discharge_q <= cfg_data;
			end else if (cfg_index == ctlm_pkg::RegTimeout) begin
				timeout_q <= cfg_data;
			end
		end
	end

	ctlm_step u_step (
		.op                (s_axis_tuser),
		.now_us            (s_axis_tdata[ctlm_pkg::TimeW-1:0]),
		.level_high        (s_axis_tdata[ctlm_pkg::TimeW]),
		.discharge_time_us (discharge_q),
		.charge_timeout_us (timeout_q),
		.state             (state_q),
		.state_nxt         (state_nxt),
		.res               (res)
	);

	// measurement state advances on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= ctlm_pkg::PH_IDLE;
			state_q.start_us    <= '0;
			state_q.status      <= ctlm_pkg::ST_NONE;
			state_q.charge_time <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	ctlm_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_xfer),
		.push_data  (res),
		.space      (s_axis_tready),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready),
		.head_data  (head)
	);

	assign m_axis_tdata = {{(ctlm_pkg::OutDataW - ctlm_pkg::ResultW){1'b0}}, head};

endmodule

### rtl/core/ctlm_checker.sv
// ----------------------------------------------------------------------------
// ctlm_checker: port-level checks for the light meter
// Watches the result stream and bound to the top level.
// ----------------------------------------------------------------------------
module ctlm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [ctlm_pkg::OutDataW-1:0] m_axis_tdata
);

	ctlm_pkg::result_t r;

	assign r = m_axis_tdata[ctlm_pkg::ResultW-1:0];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a completing step leaves the meter inactive with a real status
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.done |-> !r.active && r.status != ctlm_pkg::ST_NONE)
		else $error("done with bad status or still active");

	// charge time only reported with a valid status
	a_charge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.charge_time != '0 |-> r.status == ctlm_pkg::ST_VALID)
		else $error("charge time without valid status");

	// pin requests only on steps that leave a measurement running
	a_pin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (r.pin == ctlm_pkg::PIN_LOW || r.pin == ctlm_pkg::PIN_RELEASE)
		|-> r.active && !r.done)
		else $error("pin request on inactive step");

endmodule

bind rc_charge_time_light_meter_top ctlm_checker u_ctlm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
